@@ src/msp_pkg.sv @@
// Package with the types, constants and note table of the melody score tone player.
`timescale 1ns / 1ps

package msp_pkg;

  localparam int NAME_CHARS   = 3;
  localparam int MAX_DIGITS   = 4;
  localparam int TICKS_PER_MS = 1000;

  localparam int NAME_W   = 8 * NAME_CHARS;
  localparam int NLEN_W   = $clog2(NAME_CHARS + 1);
  localparam int DCNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int ACC_W    = 14;
  localparam int TRIM_W   = 10;
  localparam int TPMS_W   = $clog2(TICKS_PER_MS + 1);
  localparam int PROD_W   = ACC_W + TPMS_W;
  localparam int TICK_W   = 24;
  localparam int HALF_W   = 11;
  localparam int HALF_SCALE = 500000;
  localparam int NUM_NOTES  = 19;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NAME,
    PH_DIGITS
  } msp_phase_e;

  typedef struct packed {
    logic       is_tick;
    logic       is_open;
    logic       is_comma;
    logic       is_close;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] ch;
  } msp_item_t;

  typedef struct packed {
    logic buzzer_level;
    logic playing;
    logic byte_ignored;
    logic note_finished;
  } msp_result_t;

  localparam logic [NAME_W-1:0] NOTE_KEY [NUM_NOTES] = '{
    {8'h00, 8'h00, "c"}, {8'h00, 8'h00, "d"}, {8'h00, 8'h00, "e"},
    {8'h00, 8'h00, "f"}, {8'h00, 8'h00, "g"}, {8'h00, "S", "g"},
    {8'h00, 8'h00, "a"}, {8'h00, "S", "a"},   {8'h00, 8'h00, "b"},
    {8'h00, "H", "c"},   {"H", "S", "c"},     {8'h00, "H", "d"},
    {"H", "S", "d"},     {8'h00, "H", "e"},   {8'h00, "H", "f"},
    {"H", "S", "f"},     {8'h00, "H", "g"},   {"H", "S", "g"},
    {8'h00, "H", "a"}
  };

  localparam logic [NLEN_W-1:0] NOTE_LEN [NUM_NOTES] = '{
    NLEN_W'(1), NLEN_W'(1), NLEN_W'(1), NLEN_W'(1), NLEN_W'(1), NLEN_W'(2),
    NLEN_W'(1), NLEN_W'(2), NLEN_W'(1), NLEN_W'(2), NLEN_W'(3), NLEN_W'(2),
    NLEN_W'(3), NLEN_W'(2), NLEN_W'(2), NLEN_W'(3), NLEN_W'(2), NLEN_W'(3),
    NLEN_W'(2)
  };

  localparam logic [HALF_W-1:0] NOTE_HALF [NUM_NOTES] = '{
    HALF_W'(HALF_SCALE / 261), HALF_W'(HALF_SCALE / 294), HALF_W'(HALF_SCALE / 329),
    HALF_W'(HALF_SCALE / 349), HALF_W'(HALF_SCALE / 391), HALF_W'(HALF_SCALE / 415),
    HALF_W'(HALF_SCALE / 440), HALF_W'(HALF_SCALE / 455), HALF_W'(HALF_SCALE / 466),
    HALF_W'(HALF_SCALE / 523), HALF_W'(HALF_SCALE / 554), HALF_W'(HALF_SCALE / 587),
    HALF_W'(HALF_SCALE / 622), HALF_W'(HALF_SCALE / 659), HALF_W'(HALF_SCALE / 698),
    HALF_W'(HALF_SCALE / 740), HALF_W'(HALF_SCALE / 784), HALF_W'(HALF_SCALE / 830),
    HALF_W'(HALF_SCALE / 880)
  };

endpackage

@@ src/msp_front.sv @@
// Front end: classifies incoming transactions and holds them in a short queue.
`timescale 1ns / 1ps

module msp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_action_i,
  input  logic [7:0]          in_byte_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output msp_pkg::msp_item_t  item_o
);
  import msp_pkg::*;

  msp_item_t             cls;
  msp_item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]     cnt_q;
  logic                  push, pop;

  always_comb begin
    cls.is_tick  = in_action_i;
    cls.ch       = in_byte_i;
    cls.is_open  = (in_byte_i == CH_OPEN);
    cls.is_comma = (in_byte_i == CH_COMMA);
    cls.is_close = (in_byte_i == CH_CLOSE);
    cls.is_digit = (in_byte_i >= CH_ZERO) && (in_byte_i <= CH_NINE);
    cls.digit    = 4'(in_byte_i - CH_ZERO);
  end

  assign in_ready_o   = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/msp_back.sv @@
// Back end: score parser, note timer, tone generator and result register.
`timescale 1ns / 1ps

module msp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [msp_pkg::TRIM_W-1:0] cfg_wdata_i,
  input  logic                      item_valid_i,
  output logic                      item_ready_o,
  input  msp_pkg::msp_item_t        item_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output msp_pkg::msp_result_t      res_o
);
  import msp_pkg::*;

  msp_phase_e          phase_q, phase_d;
  logic [NAME_W-1:0]   name_q, name_d;
  logic [NLEN_W-1:0]   nlen_q, nlen_d;
  logic                too_long_q, too_long_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [HALF_W-1:0]   pend_half_q, pend_half_d;
  logic                pend_rest_q, pend_rest_d;
  logic [HALF_W-1:0]   half_q, half_d;
  logic [HALF_W-1:0]   hcnt_q, hcnt_d;
  logic [TICK_W-1:0]   rem_q, rem_d;
  logic                rest_q, rest_d;
  logic                pin_q, pin_d;
  logic [TRIM_W-1:0]   trim_q;
  logic                res_vld_q;
  msp_result_t         res_q, res_d;

  logic                       pop;
  logic                       hit;
  logic [HALF_W-1:0]          hit_half;
  logic [ACC_W-1:0]           ms;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W+TICK_W-1:0]   prod_ext;
  logic [TICK_W-1:0]          ticks;
  logic [TICK_W-1:0]          rem_dec;

  assign item_ready_o = !res_vld_q || res_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign res_valid_o  = res_vld_q;
  assign res_o        = res_q;

  always_comb begin
    hit      = 1'b0;
    hit_half = '0;
    for (int k = 0; k < NUM_NOTES; k++) begin
      if (name_q == NOTE_KEY[k] && nlen_q == NOTE_LEN[k]) begin
        hit      = 1'b1;
        hit_half = NOTE_HALF[k];
      end
    end
    if (too_long_q || nlen_q == '0) begin
      hit = 1'b0;
    end
  end

  assign ms       = (acc_q > ACC_W'(trim_q)) ? acc_q - ACC_W'(trim_q) : '0;
  assign prod     = PROD_W'(ms) * PROD_W'(TICKS_PER_MS);
  assign prod_ext = (PROD_W + TICK_W)'(prod);
  assign ticks    = (prod_ext > (PROD_W + TICK_W)'(TICK_MAX)) ? TICK_MAX
                                                             : prod_ext[TICK_W-1:0];
  assign rem_dec  = rem_q - 1'b1;

  always_comb begin
    phase_d     = phase_q;
    name_d      = name_q;
    nlen_d      = nlen_q;
    too_long_d  = too_long_q;
    acc_d       = acc_q;
    dcnt_d      = dcnt_q;
    pend_half_d = pend_half_q;
    pend_rest_d = pend_rest_q;
    half_d      = half_q;
    hcnt_d      = hcnt_q;
    rem_d       = rem_q;
    rest_d      = rest_q;
    pin_d       = pin_q;
    res_d       = '0;
    if (item_i.is_tick) begin
      if (rem_q != '0) begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          pin_d               = 1'b0;
          res_d.note_finished = 1'b1;
        end else if (!rest_q) begin
          if (hcnt_q <= HALF_W'(1)) begin
            pin_d  = !pin_q;
            hcnt_d = half_q;
          end else begin
            hcnt_d = hcnt_q - 1'b1;
          end
        end
      end
    end else if (rem_q != '0) begin
      res_d.byte_ignored = 1'b1;
    end else if (item_i.is_open) begin
      name_d     = '0;
      nlen_d     = '0;
      too_long_d = 1'b0;
      acc_d      = '0;
      dcnt_d     = '0;
      phase_d    = PH_NAME;
    end else begin
      case (phase_q)
        PH_NAME: begin
          if (item_i.is_comma) begin
            phase_d     = PH_DIGITS;
            pend_rest_d = !hit;
            pend_half_d = hit ? hit_half : '0;
          end else if (nlen_q < NLEN_W'(NAME_CHARS)) begin
            name_d = name_q | (NAME_W'(item_i.ch) << (8 * nlen_q));
            nlen_d = nlen_q + 1'b1;
          end else begin
            too_long_d = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (item_i.is_close) begin
            rem_d   = ticks;
            rest_d  = pend_rest_q;
            half_d  = pend_half_q;
            hcnt_d  = pend_half_q;
            pin_d   = (ticks != '0) && !pend_rest_q;
            phase_d = PH_IDLE;
          end else if (item_i.is_digit && dcnt_q < DCNT_W'(MAX_DIGITS)) begin
            acc_d  = ACC_W'(acc_q * ACC_W'(10)) + ACC_W'(item_i.digit);
            dcnt_d = dcnt_q + 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
    res_d.buzzer_level = pin_d;
    res_d.playing      = (rem_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      name_q      <= '0;
      nlen_q      <= '0;
      too_long_q  <= 1'b0;
      acc_q       <= '0;
      dcnt_q      <= '0;
      pend_half_q <= '0;
      pend_rest_q <= 1'b0;
      half_q      <= '0;
      hcnt_q      <= '0;
      rem_q       <= '0;
      rest_q      <= 1'b0;
      pin_q       <= 1'b0;
      trim_q      <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        trim_q <= cfg_wdata_i;
      end
      if (pop) begin
        phase_q     <= phase_d;
        name_q      <= name_d;
        nlen_q      <= nlen_d;
        too_long_q  <= too_long_d;
        acc_q       <= acc_d;
        dcnt_q      <= dcnt_d;
        pend_half_q <= pend_half_d;
        pend_rest_q <= pend_rest_d;
        half_q      <= half_d;
        hcnt_q      <= hcnt_d;
        rem_q       <= rem_d;
        rest_q      <= rest_d;
        pin_q       <= pin_d;
        res_vld_q   <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  a_rest_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rest_q || rem_q == '0) |-> !pin_q)
    else $error("Buzzer is high during a rest or while idle.");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.note_finished) |-> (!res_q.playing && !res_q.buzzer_level))
    else $error("A finished note still reports playing or a high level.");

  a_ignore_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.byte_ignored) |-> res_q.playing)
    else $error("A byte was dropped while no note was playing.");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> res_vld_q)
    else $error("An executed transaction left no result.");

endmodule

@@ src/melody_score_tone_player.sv @@
// Top level of the melody score tone player: front queue and back execution unit.
//
//  Channel   Direction  Signals                 Contents
//  s_axis    in         tvalid/tready/tdata/tuser  score byte, tuser = tick flag
//  m_axis    out        tvalid/tready/tdata     buzzer, playing, ignored, finished
//  cfg       in         cfg_we_i/cfg_wdata_i    duration trim in milliseconds
//
// One transaction is taken per cycle while the result is not stalled; after acceptance it
// passes through the two-entry queue, then the execution stage and result register.
// The rate is set by the execution stage, which updates the parser and timer once per
// transaction. Reset is asynchronous and needs no clearing pass. A stalled result holds
// the execution stage; the queue absorbs up to two further transactions.
`timescale 1ns / 1ps

module melody_score_tone_player (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] score_byte
  input  logic                       s_axis_tuser,   // [0] action
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] buzzer_level, [1] playing, [2] byte_ignored, [3] note_finished, [7:4] zero
  output logic [7:0]                 m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [msp_pkg::TRIM_W-1:0] cfg_wdata_i
);
  import msp_pkg::*;

  logic        item_valid, item_ready;
  msp_item_t   item;
  msp_result_t res;

  msp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .item_valid_o(item_valid),
    .item_ready_i(item_ready),
    .item_o      (item)
  );

  msp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_i      (item),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'b0000, res.note_finished, res.byte_ignored, res.playing,
                         res.buzzer_level};

endmodule
